FILE: rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// Used by the front stage, the divider cells, the top level and the checker.
package rhc_pkg;

	// Field widths of one pixel and of one result.
	localparam int COMP_BITS = 8;
	localparam int FRAC_BITS = 16;

	// Hue divisor is six times the chroma, so it needs three more bits.
	localparam int HDIV_W = COMP_BITS + 3;
	// Saturation dividend is chroma times (2^FRAC_BITS - 1).
	localparam int NUM_W = COMP_BITS + FRAC_BITS;
	// One front stage plus one divider cell per quotient bit.
	localparam int LATENCY = FRAC_BITS + 1;

	// Input beat.
	typedef struct packed {
		logic [COMP_BITS-1:0] red;
		logic [COMP_BITS-1:0] green;
		logic [COMP_BITS-1:0] blue;
	} pixel_t;

	// Output beat.
	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS-1:0] saturation;
		logic [COMP_BITS-1:0] brightness;
	} hsv_t;

	// Data handed from one divider cell to the next. The _nq words hold the
	// dividend bits not yet consumed in the top and the quotient bits found
	// so far in the bottom.
	typedef struct packed {
		logic [COMP_BITS-1:0] sat_rem;
		logic [COMP_BITS-1:0] sat_div;
		logic [FRAC_BITS-1:0] sat_nq;
		logic [HDIV_W-1:0]    hue_rem;
		logic [HDIV_W-1:0]    hue_div;
		logic [FRAC_BITS-1:0] hue_nq;
		logic [COMP_BITS-1:0] brightness;
	} div_stage_t;

endpackage

FILE: rtl/rhc_div_cell.sv
// One cell of the divider chain: finds one quotient bit of saturation and hue.
// Depends on rhc_pkg for the stage data type.
module rhc_div_cell import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_in,
	input  div_stage_t data_in,
	output logic       valid_q,
	output div_stage_t data_q
);

	logic [COMP_BITS:0] sat_trial;
	logic [COMP_BITS:0] sat_diff;
	logic               sat_ge;
	logic [HDIV_W:0]    hue_trial;
	logic [HDIV_W:0]    hue_diff;
	logic               hue_ge;
	div_stage_t         data_next;

	// Restoring step for saturation: bring down the next dividend bit.
	always_comb begin
		sat_trial = {data_in.sat_rem, data_in.sat_nq[FRAC_BITS-1]};
		sat_diff  = sat_trial - {1'b0, data_in.sat_div};
		sat_ge    = (sat_trial >= {1'b0, data_in.sat_div});
	end

	// Restoring step for hue: the low dividend bits are all zero.
	always_comb begin
		hue_trial = {data_in.hue_rem, data_in.hue_nq[FRAC_BITS-1]};
		hue_diff  = hue_trial - {1'b0, data_in.hue_div};
		hue_ge    = (hue_trial >= {1'b0, data_in.hue_div});
	end

	// Next remainders stay below their divisors, so the top bit drops.
	always_comb begin
		data_next            = data_in;
		data_next.sat_rem    = sat_ge ? sat_diff[COMP_BITS-1:0] : sat_trial[COMP_BITS-1:0];
		data_next.sat_nq     = {data_in.sat_nq[FRAC_BITS-2:0], sat_ge};
		data_next.hue_rem    = hue_ge ? hue_diff[HDIV_W-1:0] : hue_trial[HDIV_W-1:0];
		data_next.hue_nq     = {data_in.hue_nq[FRAC_BITS-2:0], hue_ge};
	end

	// Valid bit is reset; the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

endmodule

FILE: rtl/rhc_front.sv
// Front stage: value, chroma, hue sector numerator and the divider operands.
// Depends on rhc_pkg for the pixel and stage data types.
module rhc_front import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_in,
	input  pixel_t     pixel,
	output logic       valid_q,
	output div_stage_t data_q
);

	logic [COMP_BITS-1:0] max_val;
	logic [COMP_BITS-1:0] min_val;
	logic [COMP_BITS-1:0] chroma;
	logic [HDIV_W-1:0]    chroma_w;
	logic [HDIV_W-1:0]    six_c;
	logic [HDIV_W-1:0]    red_w;
	logic [HDIV_W-1:0]    green_w;
	logic [HDIV_W-1:0]    blue_w;
	logic [HDIV_W-1:0]    hue_num;
	logic [NUM_W-1:0]     sat_num;
	div_stage_t           data_next;

	// Largest and smallest component, and their difference.
	always_comb begin
		max_val = (pixel.red > pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue > max_val) begin
			max_val = pixel.blue;
		end
		min_val = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < min_val) begin
			min_val = pixel.blue;
		end
		chroma = max_val - min_val;
	end

	// Hue numerator by sector; red wins ties, then green.
	always_comb begin
		chroma_w = HDIV_W'(chroma);
		six_c    = (chroma_w << 2) + (chroma_w << 1);
		red_w    = HDIV_W'(pixel.red);
		green_w  = HDIV_W'(pixel.green);
		blue_w   = HDIV_W'(pixel.blue);
		if (pixel.red == max_val) begin
			if (pixel.green >= pixel.blue) begin
				hue_num = green_w - blue_w;
			end else begin
				hue_num = six_c - (blue_w - green_w);
			end
		end else if (pixel.green == max_val) begin
			hue_num = blue_w + (chroma_w << 1) - red_w;
		end else begin
			hue_num = red_w + (chroma_w << 2) - green_w;
		end
	end

	// Saturation dividend C * (2^F - 1). Its top part is already below the
	// value, so it seeds the remainder directly. A zero divisor becomes one;
	// its dividend is zero then, so the quotient comes out zero.
	always_comb begin
		sat_num              = {chroma, {FRAC_BITS{1'b0}}} - NUM_W'(chroma);
		data_next.sat_rem    = sat_num[NUM_W-1:FRAC_BITS];
		data_next.sat_nq     = sat_num[FRAC_BITS-1:0];
		data_next.sat_div    = (max_val == '0) ? COMP_BITS'(1) : max_val;
		data_next.hue_rem    = hue_num;
		data_next.hue_nq     = '0;
		data_next.hue_div    = (chroma == '0) ? HDIV_W'(1) : six_c;
		data_next.brightness = max_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// Pipeline: an accepted start passes one front stage, then one divider
// cell per quotient bit, 16 cells, before the done strobe.
// Throughput: one pixel per cycle; busy is always low and the chain of
// cells sets the latency. Reset clears only the valid bits of the chain.
// Depends on rhc_pkg, rhc_front and rhc_div_cell.
module rgb_to_hsv_converter import rhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output hsv_t   result
);

	logic       valid_s [FRAC_BITS+1];
	div_stage_t data_s  [FRAC_BITS+1];
	logic       accept;

	// The chain takes a beat every cycle.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (accept),
		.pixel    (pixel),
		.valid_q  (valid_s[0]),
		.data_q   (data_s[0])
	);

	// One cell per quotient bit, each feeding its neighbor.
	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_s[i]),
			.data_in  (data_s[i]),
			.valid_q  (valid_s[i+1]),
			.data_q   (data_s[i+1])
		);
	end

	// The last cell's registers drive the result beat.
	assign done              = valid_s[FRAC_BITS];
	assign result.hue        = data_s[FRAC_BITS].hue_nq;
	assign result.saturation = data_s[FRAC_BITS].sat_nq;
	assign result.brightness = data_s[FRAC_BITS].brightness;

endmodule

FILE: rtl/rhc_checker.sv
// Port-level checks on the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg for the beat types and the latency.
module rhc_checker import rhc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input pixel_t pixel,
	input logic   done,
	input hsv_t   result
);

	// The converter never holds off a pixel.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	// Every accepted pixel comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done) else $error("result missing");

	// No result appears without a pixel accepted at the matching cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done) else $error("result without pixel");

	// A black pixel gives zero hue and zero saturation.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.brightness == '0) |-> (result.saturation == '0 && result.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Brightness is at least every component of the pixel it came from.
	a_brightness: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.brightness >= $past(pixel.red, LATENCY) &&
		          result.brightness >= $past(pixel.green, LATENCY) &&
		          result.brightness >= $past(pixel.blue, LATENCY)))
		else $error("brightness below a component");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);

FILE: tb/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for the RGB to HSV converter: drives pixel beats in bursts,
// predicts hue, saturation and brightness for each one, and checks every done strobe.
// Depends on rhc_pkg and rgb_to_hsv_converter.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter import rhc_pkg::*; ();

	localparam int RANDOM_PIXELS = 800;
	localparam int QUIET_LIMIT   = 500;

	// Directed pixels, written as 24'hRRGGBB.
	localparam int N_CORNERS = 21;
	localparam logic [3*COMP_BITS-1:0] CORNERS [N_CORNERS] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
		24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'hFF00FF, 24'hFF0080, 24'hFF8000, 24'hFF7F80,
		24'hFFFF00, 24'h00FFFF, 24'h80FF40, 24'h4080FF,
		24'h7F80FF, 24'hFE00FF, 24'hFFFEFE,
		24'h010000, 24'h000100, 24'h000001
	};

	// One pending conversion: the pixel that went in and the color it should give.
	typedef struct packed {
		pixel_t px;
		hsv_t   hsv;
	} hsv_expect_t;

	// Scoreboard: predicts each conversion and matches results in order.
	class hsv_scoreboard;
		hsv_expect_t pending[$];
		int n_pixels;
		int n_results;
		int n_errors;
		int n_grey;
		int n_ties;

		// Reports a failure; only the first ten are printed.
		function void flag(string what);
			n_errors++;
			if (n_errors <= 10)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		// Exact fixed-point RGB to HSV conversion of one pixel.
		function hsv_t hsv_of(pixel_t p);
			logic [63:0] r, g, b, vmax, vmin, chroma, num, quo;
			hsv_t o;
			r = 64'(p.red);
			g = 64'(p.green);
			b = 64'(p.blue);
			vmax = r;
			if (g > vmax) vmax = g;
			if (b > vmax) vmax = b;
			vmin = r;
			if (g < vmin) vmin = g;
			if (b < vmin) vmin = b;
			chroma = vmax - vmin;
			o = '0;
			o.brightness = vmax[COMP_BITS-1:0];
			if (vmax != 0) begin
				quo = (chroma * ((64'd1 << FRAC_BITS) - 64'd1)) / vmax;
				o.saturation = quo[FRAC_BITS-1:0];
			end
			// Sector order is red, then green, then blue; a negative red-sector
			// numerator wraps by one full turn.
			if (chroma != 0) begin
				if (r == vmax)
					num = (g >= b) ? g - b : 64'd6 * chroma - (b - g);
				else if (g == vmax)
					num = b + 64'd2 * chroma - r;
				else
					num = r + 64'd4 * chroma - g;
				quo = (num << FRAC_BITS) / (64'd6 * chroma);
				o.hue = quo[FRAC_BITS-1:0];
			end
			return o;
		endfunction

		// Notes a pixel beat taken by the block.
		function void note_pixel(pixel_t p);
			hsv_expect_t e;
			e.px  = p;
			e.hsv = hsv_of(p);
			pending.push_back(e);
			n_pixels++;
			if (p.red == p.green && p.green == p.blue)
				n_grey++;
			else if (p.red == p.green || p.green == p.blue || p.red == p.blue)
				n_ties++;
		endfunction

		// Checks one result beat against the oldest expectation.
		function void check_hsv(hsv_t got);
			hsv_expect_t e;
			n_results++;
			if (pending.size() == 0) begin
				flag($sformatf("result h=%h s=%h v=%h with no pixel outstanding",
					got.hue, got.saturation, got.brightness));
				return;
			end
			e = pending.pop_front();
			if (got.hue !== e.hsv.hue || got.saturation !== e.hsv.saturation ||
					got.brightness !== e.hsv.brightness)
				flag($sformatf("rgb %h/%h/%h: expected h=%h s=%h v=%h, got h=%h s=%h v=%h",
					e.px.red, e.px.green, e.px.blue,
					e.hsv.hue, e.hsv.saturation, e.hsv.brightness,
					got.hue, got.saturation, got.brightness));
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsv_t   result;

	hsv_scoreboard sb;
	int quiet_cycles;

	rgb_to_hsv_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: records accepted pixels, checks results, and watches for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start === 1'b1 && busy === 1'b0) begin
				sb.note_pixel(pixel);
				quiet_cycles = 0;
			end else if (done === 1'b1) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (done === 1'b1)
				sb.check_hsv(result);
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Presents one pixel beat and holds it until the block takes it.
	task automatic drive_pixel(input pixel_t p);
		@(negedge clk);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Leaves start low for some cycles while the pixel bus carries junk.
	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			pixel <= pixel_t'($urandom);
		end
	endtask

	// Stops sending until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Main sequence: reset, directed pixels, random bursts, drain, verdict.
	initial begin
		int sent;
		int burst;
		int kind;
		bit paused;
		logic [COMP_BITS-1:0] top;
		pixel_t p;

		sb = new();
		quiet_cycles = 0;
		start  = 1'b0;
		pixel  = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed corners, sent back to back.
		for (int i = 0; i < N_CORNERS; i++)
			drive_pixel(pixel_t'(CORNERS[i]));
		drain_results();

		// Random bursts; most pixels are fully random, the rest aim at grey,
		// tied maxima, tiny values and saturated channels.
		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_PIXELS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
				kind = $urandom_range(0, 9);
				p = pixel_t'($urandom);
				top = COMP_BITS'($urandom);
				case (kind)
					6: begin
						p.green = p.red;
						p.blue  = p.red;
					end
					7: begin
						p.red   = top;
						p.green = top;
						p.blue  = COMP_BITS'($urandom_range(0, top));
						if ($urandom_range(0, 1)) begin
							p.blue  = top;
							p.green = COMP_BITS'($urandom_range(0, top));
						end
						if ($urandom_range(0, 2) == 0) begin
							p.red  = COMP_BITS'($urandom_range(0, top));
							p.blue = top;
						end
					end
					8: begin
						p.red   = COMP_BITS'($urandom_range(0, 3));
						p.green = COMP_BITS'($urandom_range(0, 3));
						p.blue  = COMP_BITS'($urandom_range(0, 3));
					end
					9: begin
						if ($urandom_range(0, 1)) p.red   = {COMP_BITS{$urandom_range(0, 1) == 1}};
						if ($urandom_range(0, 1)) p.green = {COMP_BITS{$urandom_range(0, 1) == 1}};
						if ($urandom_range(0, 1)) p.blue  = {COMP_BITS{$urandom_range(0, 1) == 1}};
					end
					default: ;
				endcase
				drive_pixel(p);
				sent++;
			end
			if (!paused && sent >= RANDOM_PIXELS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 12));
		end

		// Wait out the pipeline, then allow for any stray strobe.
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.flag($sformatf("%0d expected results never arrived", sb.pending.size()));

		$display("Converted %0d pixels and checked %0d results (%0d grey, %0d with tied channels).",
			sb.n_pixels, sb.n_results, sb.n_grey, sb.n_ties);
		$display("Mismatches found: %0d.", sb.n_errors);
		if (sb.n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rhc_pkg.sv
rtl/rhc_div_cell.sv
rtl/rhc_front.sv
rtl/rgb_to_hsv_converter.sv
rtl/rhc_checker.sv
tb/tb_rgb_to_hsv_converter.sv
